FILE: src/ipv4rx_pkg.sv
`timescale 1ns / 1ps

package ipv4rx_pkg;

   // largest frame length that the byte counter tracks before it saturates
   localparam logic [15:0] MAX_FRAME_BYTES = 16'hFFFF;

   // header byte positions
   localparam logic [15:0] BYTE_VER_IHL   = 16'd0;
   localparam logic [15:0] BYTE_TOTAL_HI  = 16'd2;
   localparam logic [15:0] BYTE_TOTAL_LO  = 16'd3;
   localparam logic [15:0] BYTE_FRAG_HI   = 16'd6;
   localparam logic [15:0] BYTE_FRAG_LO   = 16'd7;
   localparam logic [15:0] BYTE_PROTOCOL  = 16'd9;
   localparam logic [15:0] BYTE_SRC_FIRST = 16'd12;
   localparam logic [15:0] BYTE_SRC_LAST  = 16'd15;
   localparam logic [15:0] BYTE_DST_FIRST = 16'd16;
   localparam logic [15:0] BYTE_DST_LAST  = 16'd19;

   // header check constants
   localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
   localparam logic [3:0]  IP_VERSION_4     = 4'd4;
   localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;
   localparam logic [7:0]  LOOPBACK_NET     = 8'd127;
   localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFFFFFF;
   localparam logic [31:0] ANY_LOCAL_ADDR   = 32'h0000_0000;

   typedef enum logic [2:0] {
      VERDICT_DELIVER    = 3'd0,
      VERDICT_FRAGMENT   = 3'd1,
      VERDICT_MALFORMED  = 3'd2,
      VERDICT_BAD_HLEN   = 3'd3,
      VERDICT_BAD_CSUM   = 3'd4,
      VERDICT_NOT_FOR_US = 3'd5
   } verdict_type;

   // frame fields as they stand after the final byte of a frame
   typedef struct packed {
      logic        done;
      logic [15:0] frame_len;
      logic [5:0]  header_len;
      logic [3:0]  version;
      logic [15:0] csum;
      logic [15:0] total_field;
      logic [7:0]  protocol;
      logic [15:0] frag_word;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
   } frame_snap_type;

endpackage

FILE: src/ipv4rx_req_if.sv
`timescale 1ns / 1ps

interface ipv4rx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

FILE: src/ipv4rx_rsp_if.sv
`timescale 1ns / 1ps

interface ipv4rx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [7:0]  protocol;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [5:0]  header_bytes;
   logic [15:0] total_bytes;
   logic [15:0] payload_bytes;
   logic [12:0] fragment_offset;
   logic        more_fragments;
   logic [31:0] bad_checksum_total;
   logic [31:0] not_for_us_total;

   modport source (
      output valid, verdict, protocol, src_addr, dst_addr, header_bytes, total_bytes,
             payload_bytes, fragment_offset, more_fragments, bad_checksum_total,
             not_for_us_total,
      input  ready
   );
   modport sink (
      input  valid, verdict, protocol, src_addr, dst_addr, header_bytes, total_bytes,
             payload_bytes, fragment_offset, more_fragments, bad_checksum_total,
             not_for_us_total,
      output ready
   );
endinterface

FILE: src/ipv4_receive_header_check_top.sv
`timescale 1ns / 1ps

// IPv4 receive header check. Frame bytes enter on req_chan one per transaction, with
// last_byte set on the final byte; one result leaves on rsp_chan per frame, in the cycle
// after that final byte is taken from the input register. The block takes one byte per
// clock cycle sustained: each byte passes an input register, a combinational update of
// the running ones-complement sum and the captured header fields, and, for the final
// byte, the ordered header checks into the result register. The only stall comes from
// a final byte that meets a result still waiting on rsp_chan. csr_wr_data sets the local
// address (zero accepts any destination); users write it with no frame open (unchecked).

module ipv4_receive_header_check_top (
   input  logic         clock,
   input  logic         reset,
   ipv4rx_req_if.sink   req_chan,
   ipv4rx_rsp_if.source rsp_chan,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);
   import ipv4rx_pkg::*;

   frame_snap_type snap;
   logic           out_free;

   // byte intake and header field capture
   ipv4rx_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .out_free (out_free),
      .snap     (snap)
   );

   // header checks, drop counters and result register
   ipv4rx_verdict u_verdict (
      .clock       (clock),
      .reset       (reset),
      .snap        (snap),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .out_free    (out_free),
      .rsp         (rsp_chan)
   );

endmodule

FILE: src/ipv4rx_accum.sv
`timescale 1ns / 1ps

module ipv4rx_accum (
   input  logic                        clock,
   input  logic                        reset,
   ipv4rx_req_if.sink                  req,
   input  logic                        out_free,
   output ipv4rx_pkg::frame_snap_type  snap
);
   import ipv4rx_pkg::*;

   logic        a_valid_ff, a_valid_in;
   logic [7:0]  a_byte_ff;
   logic        a_last_ff;
   logic        a_adv;

   logic [15:0] count_ff, count_in;
   logic [5:0]  hlen_ff, hlen_in;
   logic [3:0]  ver_ff, ver_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] frag_ff, frag_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;

   logic [15:0] idx;
   logic        in_header;
   logic [16:0] sum_raw;

   // input register advances unless a final byte waits on a busy result register
   assign a_adv     = a_valid_ff && (!a_last_ff || out_free);
   assign req.ready = !a_valid_ff || a_adv;
   assign a_valid_in = req.ready ? req.valid : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         a_byte_ff <= req.frame_byte;
         a_last_ff <= req.last_byte;
      end
   end

   // per-byte update of the header fields and the running sum
   always_comb begin
      idx      = count_ff;
      ver_in   = ver_ff;
      hlen_in  = hlen_ff;
      hold_in  = hold_ff;
      sum_in   = sum_ff;
      total_in = total_ff;
      frag_in  = frag_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      sum_raw  = {1'b0, sum_ff} + {1'b0, hold_ff, a_byte_ff};

      if (idx == BYTE_VER_IHL) begin
         ver_in  = a_byte_ff[7:4];
         hlen_in = {a_byte_ff[3:0], 2'b00};
      end
      in_header = idx < {10'd0, hlen_in};
      if (in_header) begin
         if (!idx[0]) begin
            hold_in = a_byte_ff;
         end else begin
            // end-around carry
            sum_in = sum_raw[16] ? (sum_raw[15:0] + 16'd1) : sum_raw[15:0];
         end
      end
      if (idx == BYTE_TOTAL_HI) total_in = {a_byte_ff, total_ff[7:0]};
      if (idx == BYTE_TOTAL_LO) total_in = {total_ff[15:8], a_byte_ff};
      if (idx == BYTE_FRAG_HI)  frag_in  = {a_byte_ff, frag_ff[7:0]};
      if (idx == BYTE_FRAG_LO)  frag_in  = {frag_ff[15:8], a_byte_ff};
      if (idx == BYTE_PROTOCOL) proto_in = a_byte_ff;
      if (idx >= BYTE_SRC_FIRST && idx <= BYTE_SRC_LAST) src_in = {src_ff[23:0], a_byte_ff};
      if (idx >= BYTE_DST_FIRST && idx <= BYTE_DST_LAST) dst_in = {dst_ff[23:0], a_byte_ff};

      // saturating byte count
      count_in = (count_ff == MAX_FRAME_BYTES) ? count_ff : (count_ff + 16'd1);
   end

   // frame state: cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset || (a_adv && a_last_ff)) begin
         count_ff <= '0;
         hlen_ff  <= '0;
         ver_ff   <= '0;
         sum_ff   <= '0;
         hold_ff  <= '0;
         total_ff <= '0;
         proto_ff <= '0;
         frag_ff  <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
      end else if (a_adv) begin
         count_ff <= count_in;
         hlen_ff  <= hlen_in;
         ver_ff   <= ver_in;
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         total_ff <= total_in;
         proto_ff <= proto_in;
         frag_ff  <= frag_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
      end
   end

   // fields of the finished frame toward the verdict stage
   always_comb begin
      snap.done        = a_adv && a_last_ff;
      snap.frame_len   = count_in;
      snap.header_len  = hlen_in;
      snap.version     = ver_in;
      snap.csum        = sum_in;
      snap.total_field = total_in;
      snap.protocol    = proto_in;
      snap.frag_word   = frag_in;
      snap.src_addr    = src_in;
      snap.dst_addr    = dst_in;
   end

   // a frame always starts at byte zero after its final byte
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (a_adv && a_last_ff) |=> (count_ff == 16'd0 && sum_ff == 16'd0))
      else $error("frame state not cleared after final byte");

   // a final byte never leaves the input register while the result side is full
   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_last_ff && !out_free) |=> (a_valid_ff && a_last_ff))
      else $error("final byte dropped while result stalled");

endmodule

FILE: src/ipv4rx_verdict.sv
`timescale 1ns / 1ps

module ipv4rx_verdict (
   input  logic                        clock,
   input  logic                        reset,
   input  ipv4rx_pkg::frame_snap_type  snap,
   input  logic                        csr_wr_en,
   input  logic [31:0]                 csr_wr_data,
   output logic                        out_free,
   ipv4rx_rsp_if.source                rsp
);
   import ipv4rx_pkg::*;

   logic [31:0] local_addr_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] bad_csum_ff, bad_csum_in;
   logic [31:0] not_us_ff, not_us_in;

   verdict_type verdict;
   logic [15:0] hlen16;
   logic [15:0] total;
   logic        keep_fields;

   verdict_type v_ff;
   logic [7:0]  proto_ff;
   logic [31:0] src_ff, dst_ff;
   logic [5:0]  hlen_ff;
   logic [15:0] total_ff, payload_ff;
   logic [12:0] frag_off_ff;
   logic        more_frag_ff;

   // local address register
   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
      end else if (csr_wr_en) begin
         local_addr_ff <= csr_wr_data;
      end
   end

   // ordered header checks
   always_comb begin
      hlen16 = {10'd0, snap.header_len};
      total  = snap.total_field;
      if (total < hlen16 || total > snap.frame_len) total = snap.frame_len;

      if (snap.frame_len < MIN_HEADER_BYTES || snap.version != IP_VERSION_4) begin
         verdict = VERDICT_MALFORMED;
      end else if (hlen16 < MIN_HEADER_BYTES || snap.frame_len < hlen16) begin
         verdict = VERDICT_BAD_HLEN;
      end else if (snap.csum != CSUM_GOOD) begin
         verdict = VERDICT_BAD_CSUM;
      end else if (snap.dst_addr[31:24] != LOOPBACK_NET && local_addr_ff != ANY_LOCAL_ADDR
                   && snap.dst_addr != local_addr_ff && snap.dst_addr != BROADCAST_ADDR) begin
         verdict = VERDICT_NOT_FOR_US;
      end else if (snap.frag_word[13] || snap.frag_word[12:0] != 13'd0) begin
         verdict = VERDICT_FRAGMENT;
      end else begin
         verdict = VERDICT_DELIVER;
      end

      keep_fields = (verdict == VERDICT_DELIVER) || (verdict == VERDICT_FRAGMENT)
                    || (verdict == VERDICT_NOT_FOR_US);

      bad_csum_in = bad_csum_ff + ((verdict == VERDICT_BAD_CSUM) ? 32'd1 : 32'd0);
      not_us_in   = not_us_ff + ((verdict == VERDICT_NOT_FOR_US) ? 32'd1 : 32'd0);
   end

   // result register handshake
   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = snap.done ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         bad_csum_ff  <= '0;
         not_us_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (snap.done) begin
            bad_csum_ff <= bad_csum_in;
            not_us_ff   <= not_us_in;
         end
      end
   end

   // result payload, zeroed fields for early rejects
   always_ff @(posedge clock) begin
      if (snap.done) begin
         v_ff         <= verdict;
         proto_ff     <= keep_fields ? snap.protocol : 8'd0;
         src_ff       <= keep_fields ? snap.src_addr : 32'd0;
         dst_ff       <= keep_fields ? snap.dst_addr : 32'd0;
         hlen_ff      <= keep_fields ? snap.header_len : 6'd0;
         total_ff     <= keep_fields ? total : 16'd0;
         payload_ff   <= keep_fields ? (total - hlen16) : 16'd0;
         frag_off_ff  <= keep_fields ? snap.frag_word[12:0] : 13'd0;
         more_frag_ff <= keep_fields ? snap.frag_word[13] : 1'b0;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.verdict            = v_ff;
   assign rsp.protocol           = proto_ff;
   assign rsp.src_addr           = src_ff;
   assign rsp.dst_addr           = dst_ff;
   assign rsp.header_bytes       = hlen_ff;
   assign rsp.total_bytes        = total_ff;
   assign rsp.payload_bytes      = payload_ff;
   assign rsp.fragment_offset    = frag_off_ff;
   assign rsp.more_fragments     = more_frag_ff;
   assign rsp.bad_checksum_total = bad_csum_ff;
   assign rsp.not_for_us_total   = not_us_ff;

   // a finished frame only arrives when the result register can take it
   v_done_has_room: assert property (@(posedge clock) disable iff (reset)
      snap.done |-> out_free)
      else $error("finished frame arrived while result register full");

   // checksum drops bump the counter by exactly one
   v_csum_count: assert property (@(posedge clock) disable iff (reset)
      (snap.done && verdict == VERDICT_BAD_CSUM) |=> (bad_csum_ff == $past(bad_csum_ff) + 32'd1))
      else $error("bad checksum counter not advanced");

endmodule
